### hdl/rabq_pkg.sv
// shared constants and control types for the relu / pool / batch-norm requantiser
package rabq_pkg;

	// field and register widths
	localparam int SAMPLE_W = 32;
	localparam int PORT_W   = 32;
	localparam int ACC_W    = 35;
	localparam int DIVD_W   = ACC_W + 1;
	localparam int FACT_W   = 31;
	localparam int OFF_W    = 32;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_W    = 8;

	// clamp value width: one bit above the sample so the threshold always fits
	localparam int CLAMP_W  = SAMPLE_W + 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd2;

	// mode codes
	localparam logic MODE_BN    = 1'b0;
	localparam logic MODE_PLAIN = 1'b1;

	// reset values
	localparam logic [FACT_W-1:0] FACTOR_RESET = 31'd8;

	// window and divider timing
	localparam int POOL_SHIFT = 3;
	localparam logic [2:0] POOL_LAST = 3'd7;
	localparam int DIV_STEPS = DIVD_W / 2;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// int8 clip limits
	localparam int CLIP_HI = 127;

	// controller to datapath commands
	typedef struct packed {
		logic acc;   // add the incoming word to the window sum
		logic prep;  // close the window and load the divider
		logic step;  // two quotient bits
		logic emit;  // load the output register
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic plain;     // mode in force
		logic out_free;  // output register can take a word this cycle
	} sts_t;

endpackage

### hdl/rabq_ctrl.sv
// controller: window count, divider sequencing and output hand-off
module rabq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  rabq_pkg::sts_t sts,
	output rabq_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t                      state_q;
	logic [2:0]                  cnt_q;
	logic [rabq_pkg::STEP_W-1:0] step_q;
	logic                        in_take;

	// input is only taken while no window is being closed
	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;

	// commands decoded from state
	always_comb begin
		cmd      = '0;
		cmd.acc  = in_take;
		cmd.prep = (state_q == ST_PREP);
		cmd.step = (state_q == ST_DIV);
		cmd.emit = (state_q == ST_EMIT) && sts.out_free;
	end

	// state, window count and divide step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						cnt_q <= cnt_q + 3'd1;
						if (cnt_q == rabq_pkg::POOL_LAST) begin
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					step_q <= '0;
					if (sts.plain == rabq_pkg::MODE_PLAIN) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + rabq_pkg::STEP_W'(1);
					if (step_q == rabq_pkg::STEP_W'(rabq_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### hdl/rabq_dpath.sv
// datapath: config registers, clamp and accumulate, serial divider, clip and output register
module rabq_dpath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [rabq_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rabq_pkg::CFG_W-1:0]            cfg_data,
	input  logic signed [rabq_pkg::PORT_W-1:0]    sample,
	input  logic                                  out_stall,
	input  rabq_pkg::cmd_t                        cmd,
	output rabq_pkg::sts_t                        sts,
	output logic                                  out_valid,
	output logic signed [rabq_pkg::OUT_W-1:0]     pooled
);

	logic                                 mode_q;
	logic [rabq_pkg::FACT_W-1:0]          factor_q;
	logic signed [rabq_pkg::OFF_W-1:0]    offset_q;
	logic signed [rabq_pkg::ACC_W-1:0]    sum_q;
	logic [rabq_pkg::DIVD_W-1:0]          quo_q;
	logic [rabq_pkg::FACT_W-1:0]          rem_q;
	logic                                 neg_q;
	logic                                 plain_q;
	logic signed [rabq_pkg::OUT_W-1:0]    plain_res_q;
	logic                                 out_valid_q;
	logic signed [rabq_pkg::OUT_W-1:0]    pooled_q;

	logic signed [rabq_pkg::OFF_W-1:0]    off_sh;
	logic signed [rabq_pkg::CLAMP_W-1:0]  thr;
	logic signed [rabq_pkg::CLAMP_W-1:0]  s_ext;
	logic signed [rabq_pkg::CLAMP_W-1:0]  s_clamp;
	logic signed [rabq_pkg::ACC_W-1:0]    sum_next;
	logic signed [rabq_pkg::DIVD_W-1:0]   dividend;
	logic signed [rabq_pkg::ACC_W-1:0]    sum_sh;
	logic [rabq_pkg::FACT_W-1:0]          dvs;
	logic [rabq_pkg::FACT_W:0]            r_a;
	logic [rabq_pkg::FACT_W:0]            r_b;
	logic [rabq_pkg::FACT_W:0]            r_a2;
	logic [rabq_pkg::FACT_W:0]            r_b2;
	logic                                 ge_a;
	logic                                 ge_b;
	logic signed [rabq_pkg::OUT_W-1:0]    div_res;

	// clip a signed sum to int8
	function automatic logic signed [rabq_pkg::OUT_W-1:0] clip_sum(
		input logic signed [rabq_pkg::ACC_W-1:0] v
	);
		logic signed [rabq_pkg::OUT_W-1:0] r;
		if (v > rabq_pkg::ACC_W'(rabq_pkg::CLIP_HI)) begin
			r = rabq_pkg::OUT_W'(rabq_pkg::CLIP_HI);
		end else if (v < -rabq_pkg::ACC_W'(rabq_pkg::CLIP_HI + 1)) begin
			r = rabq_pkg::OUT_W'(-(rabq_pkg::CLIP_HI + 1));
		end else begin
			r = v[rabq_pkg::OUT_W-1:0];
		end
		return r;
	endfunction

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= rabq_pkg::MODE_BN;
			factor_q <= rabq_pkg::FACTOR_RESET;
			offset_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rabq_pkg::REG_MODE:   mode_q   <= cfg_data[0];
				rabq_pkg::REG_FACTOR: factor_q <= cfg_data[rabq_pkg::FACT_W-1:0];
				rabq_pkg::REG_OFFSET: offset_q <= cfg_data[rabq_pkg::OFF_W-1:0];
				default: ;
			endcase
		end
	end

	// per-word floor: -(offset >>> 3) in batch-norm mode, zero in plain mode
	always_comb begin
		off_sh = offset_q >>> rabq_pkg::POOL_SHIFT;
		if (mode_q == rabq_pkg::MODE_BN) begin
			thr = -{off_sh[rabq_pkg::OFF_W-1], off_sh};
		end else begin
			thr = '0;
		end
		s_ext = {{(rabq_pkg::CLAMP_W - rabq_pkg::SAMPLE_W){sample[rabq_pkg::SAMPLE_W-1]}},
			sample[rabq_pkg::SAMPLE_W-1:0]};
		s_clamp  = (s_ext < thr) ? thr : s_ext;
		sum_next = sum_q + {{(rabq_pkg::ACC_W - rabq_pkg::CLAMP_W){s_clamp[rabq_pkg::CLAMP_W-1]}},
			s_clamp};
	end

	// window close: offset-adjusted dividend and shifted sum
	assign dividend = {sum_q[rabq_pkg::ACC_W-1], sum_q}
		+ {{(rabq_pkg::DIVD_W - rabq_pkg::OFF_W){offset_q[rabq_pkg::OFF_W-1]}}, offset_q};
	assign sum_sh = sum_q >>> rabq_pkg::POOL_SHIFT;

	// radix-4 restoring divide step on magnitudes
	always_comb begin
		dvs  = (factor_q == '0) ? rabq_pkg::FACT_W'(1) : factor_q;
		r_a  = {rem_q, quo_q[rabq_pkg::DIVD_W-1]};
		ge_a = (r_a >= {1'b0, dvs});
		r_a2 = ge_a ? (r_a - {1'b0, dvs}) : r_a;
		r_b  = {r_a2[rabq_pkg::FACT_W-1:0], quo_q[rabq_pkg::DIVD_W-2]};
		ge_b = (r_b >= {1'b0, dvs});
		r_b2 = ge_b ? (r_b - {1'b0, dvs}) : r_b;
	end

	// quotient sign and int8 clip
	always_comb begin
		if (neg_q) begin
			if (quo_q > rabq_pkg::DIVD_W'(rabq_pkg::CLIP_HI + 1)) begin
				div_res = rabq_pkg::OUT_W'(-(rabq_pkg::CLIP_HI + 1));
			end else begin
				div_res = -quo_q[rabq_pkg::OUT_W-1:0];
			end
		end else begin
			if (quo_q > rabq_pkg::DIVD_W'(rabq_pkg::CLIP_HI)) begin
				div_res = rabq_pkg::OUT_W'(rabq_pkg::CLIP_HI);
			end else begin
				div_res = quo_q[rabq_pkg::OUT_W-1:0];
			end
		end
	end

	// window sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.prep) begin
			sum_q <= '0;
		end else if (cmd.acc) begin
			sum_q <= sum_next;
		end
	end

	// divider and plain-mode result
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			neg_q       <= dividend[rabq_pkg::DIVD_W-1];
			quo_q       <= dividend[rabq_pkg::DIVD_W-1] ? 
				rabq_pkg::DIVD_W'(-dividend) : rabq_pkg::DIVD_W'(dividend);
			rem_q       <= '0;
			plain_q     <= mode_q;
			plain_res_q <= clip_sum(sum_sh);
		end else if (cmd.step) begin
			quo_q <= {quo_q[rabq_pkg::DIVD_W-3:0], ge_a, ge_b};
			rem_q <= r_b2[rabq_pkg::FACT_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pooled_q <= (plain_q == rabq_pkg::MODE_PLAIN) ? plain_res_q : div_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign pooled       = pooled_q;
	assign sts.plain    = mode_q;
	assign sts.out_free = !out_valid_q || !out_stall;

endmodule

### hdl/relu_avgpool8_batchnorm_requant_unit.sv
// top level of the relu / average-pool-by-eight / batch-norm int8 requantiser
//
//  channel   direction  handshake           payload
//  input     in         in_valid/in_stall   sample  (32 bits, signed)
//  output    out        out_valid/out_stall pooled  (8 bits, signed)
//  config    in         cfg_we              cfg_index (2 bits), cfg_data (32 bits)
//
// sample words are taken while no window is being closed; the eighth word of a
// window stalls the input while the window is closed, the radix-4 serial divider
// runs in batch-norm mode (two quotient bits per step) and the output register is
// loaded once it is free; plain mode skips the divider
// asynchronous active-low reset clears the window sum and count and loads the
// register defaults (mode 0, factor 8, offset 0)
// a stalled output only holds up the input once the next window is ready to emit
module relu_avgpool8_batchnorm_requant_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [rabq_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rabq_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [rabq_pkg::PORT_W-1:0]    sample,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [rabq_pkg::OUT_W-1:0]     pooled
);

	rabq_pkg::cmd_t cmd;
	rabq_pkg::sts_t sts;

	// sequencing
	rabq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic and storage
	rabq_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.pooled    (pooled)
	);

endmodule

### hdl/rabq_chk.sv
// port-level checker for the requantiser, bound to the top level
module rabq_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [rabq_pkg::OUT_W-1:0]  pooled
);

	logic [2:0] win_q;
	logic [1:0] owed_q;
	logic       in_take;
	logic       out_take;
	logic       win_done;
	logic       held_q;

	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;
	assign win_done = in_take && (win_q == rabq_pkg::POOL_LAST);

	// words taken in the current window, and windows closed but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			owed_q <= '0;
			held_q <= 1'b0;
		end else begin
			if (in_take) begin
				win_q <= win_q + 3'd1;
			end
			owed_q <= owed_q + {1'b0, win_done} - {1'b0, out_take};
			held_q <= out_valid && out_stall;
		end
	end

	// a stalled word stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pooled))
		else $error("stalled output word changed");

	// no word without a closed window
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> owed_q != 2'd0)
		else $error("output word with no closed window");

	// a fresh word only appears on a window boundary
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !held_q |-> win_q == 3'd0)
		else $error("output word in the middle of a window");

	// with one word waiting and another window closed, input is held off
	assert property (@(posedge clk) disable iff (!arst_n)
		owed_q == 2'd2 |-> in_stall && owed_q != 2'd3)
		else $error("input taken with two words owed");

endmodule

bind relu_avgpool8_batchnorm_requant_unit rabq_chk u_rabq_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pooled    (pooled)
);

### tb/tb_top.sv
// self-checking testbench for the relu / average-pool-by-eight / batch-norm requantiser
module tb_top;

	// cycles with no word moving before the run is abandoned
	localparam int STALL_LIMIT = 5000;
	// settling time after the last expected word, longer than one batch-norm window
	localparam int SETTLE_CYCLES = 40;
	// length of the long output hold-off
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_WORDS = 800;

	localparam logic signed [rabq_pkg::SAMPLE_W-1:0] S_MAX = 32'h7FFF_FFFF;
	localparam logic signed [rabq_pkg::SAMPLE_W-1:0] S_MIN = 32'h8000_0000;

	// expected pooled words worked out from the accepted samples
	class pool_scoreboard;
		logic                              mode;
		logic [rabq_pkg::FACT_W-1:0]       factor;
		logic signed [rabq_pkg::OFF_W-1:0] offset;
		longint                            win_sum;
		int unsigned                       win_cnt;
		logic signed [rabq_pkg::OUT_W-1:0] pending_pooled[$];
		int                                errors;

		function new();
			mode    = rabq_pkg::MODE_BN;
			factor  = rabq_pkg::FACTOR_RESET;
			offset  = '0;
			win_sum = 0;
			win_cnt = 0;
			errors  = 0;
		endfunction

		function void set_reg(logic [rabq_pkg::CFG_IDX_W-1:0] idx,
			logic [rabq_pkg::CFG_W-1:0] data);
			case (idx)
				rabq_pkg::REG_MODE:   mode = data[0];
				rabq_pkg::REG_FACTOR: factor = data[rabq_pkg::FACT_W-1:0];
				rabq_pkg::REG_OFFSET: offset = data[rabq_pkg::OFF_W-1:0];
				default: ;
			endcase
		endfunction

		// per-sample relu floor in force right now
		function longint relu_floor();
			longint off_l;
			off_l = offset;
			if (mode == rabq_pkg::MODE_BN)
				return -(off_l >>> rabq_pkg::POOL_SHIFT);
			return 0;
		endfunction

		function void note_sample(logic signed [rabq_pkg::SAMPLE_W-1:0] s);
			longint v;
			longint lo;
			longint off_l;
			longint divisor;
			longint r;
			v  = s;
			lo = relu_floor();
			if (v < lo)
				v = lo;
			win_sum += v;
			if (win_cnt != rabq_pkg::POOL_LAST) begin
				win_cnt++;
				return;
			end
			win_cnt = 0;
			// close the window with the mode and registers in force now
			if (mode == rabq_pkg::MODE_BN) begin
				off_l   = offset;
				divisor = factor;
				if (divisor == 0)
					divisor = 1;
				r = (win_sum + off_l) / divisor;
			end else begin
				r = win_sum >>> rabq_pkg::POOL_SHIFT;
			end
			if (r > rabq_pkg::CLIP_HI)
				r = rabq_pkg::CLIP_HI;
			else if (r < -(rabq_pkg::CLIP_HI + 1))
				r = -(rabq_pkg::CLIP_HI + 1);
			pending_pooled.push_back(r[rabq_pkg::OUT_W-1:0]);
			win_sum = 0;
		endfunction

		function void check_pooled(logic signed [rabq_pkg::OUT_W-1:0] got);
			logic signed [rabq_pkg::OUT_W-1:0] want;
			if (pending_pooled.size() == 0) begin
				$error("pooled word with none expected: got %0d", got);
				errors++;
				return;
			end
			want = pending_pooled.pop_front();
			if (got !== want) begin
				$error("pooled mismatch: expected %0d, got %0d", want, got);
				errors++;
			end
		endfunction
	endclass

	logic                                   clk;
	logic                                   arst_n;
	logic                                   cfg_we;
	logic [rabq_pkg::CFG_IDX_W-1:0]         cfg_index;
	logic [rabq_pkg::CFG_W-1:0]             cfg_data;
	logic                                   in_valid;
	logic                                   in_stall;
	logic signed [rabq_pkg::PORT_W-1:0]     sample;
	logic                                   out_valid;
	logic                                   out_stall;
	logic signed [rabq_pkg::OUT_W-1:0]      pooled;

	pool_scoreboard sb;
	bit             hold_req;
	int unsigned    burst_left;
	int unsigned    idle_cycles;

	relu_avgpool8_batchnorm_requant_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pooled    (pooled)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// register write, returning after cfg_we has been dropped again
	task automatic write_reg(input logic [rabq_pkg::CFG_IDX_W-1:0] idx,
		input logic [rabq_pkg::CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.set_reg(idx, data);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// offer one sample word and wait for it to be taken; bursts and gaps unless steady
	task automatic send_sample(input logic signed [rabq_pkg::SAMPLE_W-1:0] v,
		input bit steady);
		int unsigned gap;
		in_valid <= 1'b1;
		sample   <= v;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_sample(v);
		if (!steady) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end else begin
				burst_left--;
			end
		end
	endtask

	// drain every expected word, then let the block settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending_pooled.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// new random settings, extremes weighted in
	task automatic shuffle_config();
		logic [rabq_pkg::CFG_W-1:0] fac;
		logic [rabq_pkg::CFG_W-1:0] off;
		logic                       m;
		m = ($urandom_range(0, 1) == 0) ? rabq_pkg::MODE_BN : rabq_pkg::MODE_PLAIN;
		case ($urandom_range(0, 5))
			0: fac = 1;
			1: fac = 32'h7FFF_FFFF;
			2: fac = rabq_pkg::FACTOR_RESET;
			3: fac = $urandom_range(1, 64);
			4: fac = $urandom_range(1, 4096);
			default: fac = $urandom >> 1;
		endcase
		case ($urandom_range(0, 4))
			0: off = S_MIN;
			1: off = S_MAX;
			2: off = '0;
			3: off = int'($urandom_range(0, 4000)) - 2000;
			default: off = $urandom;
		endcase
		write_reg(rabq_pkg::REG_MODE, rabq_pkg::CFG_W'(m));
		write_reg(rabq_pkg::REG_FACTOR, fac);
		write_reg(rabq_pkg::REG_OFFSET, off);
	endtask

	// sample mix: full range, extremes, near the relu floor and small values
	function automatic logic signed [rabq_pkg::SAMPLE_W-1:0] pick_sample();
		longint v;
		case ($urandom_range(0, 9))
			0, 1: v = int'($urandom);
			2: begin
				case ($urandom_range(0, 3))
					0: v = S_MAX;
					1: v = S_MIN;
					2: v = 0;
					default: v = -1;
				endcase
			end
			3, 4, 5, 6: v = sb.relu_floor() + (int'($urandom_range(0, 2000)) - 1000);
			default: v = int'($urandom_range(0, 2000)) - 1000;
		endcase
		return v[rabq_pkg::SAMPLE_W-1:0];
	endfunction

	// output side: stall styles of varying length, plus the long hold-off on request
	initial begin
		int unsigned style;
		int unsigned style_left;
		int unsigned phase_cnt;
		out_stall  <= 1'b0;
		style      = 0;
		style_left = 0;
		phase_cnt  = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (style_left == 0) begin
					style      = $urandom_range(0, 3);
					style_left = $urandom_range(20, 200);
				end
				style_left--;
				phase_cnt++;
				case (style)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ((phase_cnt % 5) < 2);
				endcase
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_pooled(pooled);
	end

	// watchdog on cycles where no word moves
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[relu_avgpool8_batchnorm_requant_unit] ERROR");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		int unsigned sent;
		int unsigned n;
		int unsigned phase;
		sb          = new();
		hold_req    = 1'b0;
		burst_left  = 0;
		idle_cycles = 0;
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		sample      <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: batch-norm, factor 8, offset 0, extremes of the sample
		send_sample(S_MAX, 1'b0);
		send_sample(S_MIN, 1'b0);
		send_sample(-1, 1'b0);
		send_sample(0, 1'b0);
		send_sample(1, 1'b0);
		send_sample(S_MAX, 1'b0);
		send_sample(100, 1'b0);
		send_sample(-100, 1'b0);
		wait_idle();

		// plain average with a full window
		write_reg(rabq_pkg::REG_MODE, rabq_pkg::CFG_W'(rabq_pkg::MODE_PLAIN));
		send_sample(S_MAX, 1'b0);
		send_sample(S_MAX, 1'b0);
		send_sample(S_MAX, 1'b0);
		send_sample(S_MIN, 1'b0);
		send_sample(-1, 1'b0);
		send_sample(1, 1'b0);
		send_sample(7, 1'b0);
		send_sample(0, 1'b0);
		wait_idle();

		// half a window in plain mode, then batch-norm with zero divisor and
		// most negative offset: the window closes below the clip
		send_sample(S_MIN, 1'b0);
		send_sample(-7, 1'b0);
		send_sample(3, 1'b0);
		send_sample(0, 1'b0);
		wait_idle();
		write_reg(rabq_pkg::REG_FACTOR, '0);
		write_reg(rabq_pkg::REG_OFFSET, S_MIN);
		write_reg(rabq_pkg::REG_MODE, rabq_pkg::CFG_W'(rabq_pkg::MODE_BN));
		send_sample(-1, 1'b0);
		send_sample(-100, 1'b0);
		send_sample(0, 1'b0);
		send_sample(5, 1'b0);
		wait_idle();

		// random phases of random length so settings also change mid-window
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_WORDS) begin
			shuffle_config();
			if (phase == 2) begin
				// long output hold-off while words keep coming
				hold_req = 1'b1;
				repeat (60) begin
					send_sample(pick_sample(), 1'b1);
					sent++;
				end
			end else begin
				n = $urandom_range(1, 100);
				repeat (n) begin
					send_sample(pick_sample(), 1'b0);
					sent++;
				end
			end
			wait_idle();
			phase++;
		end

		if (sb.errors == 0)
			$display("[relu_avgpool8_batchnorm_requant_unit] OK");
		else
			$display("[relu_avgpool8_batchnorm_requant_unit] ERROR");
		$finish;
	end

endmodule
